@@ hdl/btndb_pkg.sv @@
// shared types and constants for the button array debouncer
package btndb_pkg;

   // number of button lanes built and width of the per-button fields
   localparam int unsigned MAX_BUTTONS = 8;
   localparam int unsigned BUTTONS_W   = 8;

   // field and register widths
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned DEBOUNCE_W  = 16;
   localparam int unsigned ACTIVE_W    = 4;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_MS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_BUTTONS = 1'b1;

   // register reset values
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RESET    = 16'd50;
   localparam logic [ACTIVE_W-1:0]   ACTIVE_BUTTONS_RESET = 4'd8;

   // per-lane control from the top level
   typedef struct packed {
      logic sample;   // take one sample step this cycle
      logic clear;    // clear press and release flags this cycle
      logic raw;      // raw button level
   } lane_ctl_type;

   // per-lane status toward the result register
   typedef struct packed {
      logic pressed;       // debounced pressed phase after this sample
      logic press_flag;    // latched press, before any clear
      logic release_flag;  // latched release, before any clear
      logic qualified;     // a press or release qualified on this sample
   } lane_stat_type;

endpackage

@@ hdl/btndb_lane.sv @@
// one button lane: four-phase debounce machine with sticky edge flags
module btndb_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  btndb_pkg::lane_ctl_type             ctl,
   input  logic [btndb_pkg::TIME_W-1:0]        time_ms,
   input  logic [btndb_pkg::DEBOUNCE_W-1:0]    debounce_ms,
   output btndb_pkg::lane_stat_type            stat
);

   localparam logic [1:0] PH_RELEASED  = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
   localparam logic [1:0] PH_PRESSED   = 2'd2;
   localparam logic [1:0] PH_RELEASING = 2'd3;

   logic [1:0]                     phase_ff, phase_in;
   logic [btndb_pkg::TIME_W-1:0]   change_time_ff, change_time_in;
   logic                           prev_raw_ff, prev_raw_in;
   logic                           press_ff, press_in;
   logic                           release_ff, release_in;

   logic [btndb_pkg::TIME_W-1:0]   held;
   logic                           done;
   logic [1:0]                     step_phase;
   logic                           step_press, step_release;
   logic                           press_view, release_view;

   // wrapping elapsed time since the last phase change
   assign held = time_ms - change_time_ff;
   assign done = held >= {{(btndb_pkg::TIME_W-btndb_pkg::DEBOUNCE_W){1'b0}}, debounce_ms};

   always_comb begin
      step_phase   = phase_ff;
      step_press   = 1'b0;
      step_release = 1'b0;
      case (phase_ff)
         PH_RELEASED: begin
            if (ctl.raw && !prev_raw_ff) begin
               step_phase = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (!ctl.raw) begin
               step_phase = PH_RELEASED;
            end else if (done) begin
               step_phase = PH_PRESSED;
               step_press = 1'b1;
            end
         end
         PH_PRESSED: begin
            if (!ctl.raw) begin
               step_phase = PH_RELEASING;
            end
         end
         default: begin
            if (ctl.raw) begin
               step_phase = PH_PRESSED;
            end else if (done) begin
               step_phase   = PH_RELEASED;
               step_release = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      change_time_in = change_time_ff;
      prev_raw_in    = prev_raw_ff;
      if (ctl.sample) begin
         phase_in    = step_phase;
         prev_raw_in = ctl.raw;
         if (step_phase != phase_ff) begin
            change_time_in = time_ms;
         end
      end
   end

   // flags as seen by this word: updated by a sample, not yet cleared by a read
   assign press_view   = press_ff   | (ctl.sample & step_press);
   assign release_view = release_ff | (ctl.sample & step_release);
   assign press_in     = press_view   & ~ctl.clear;
   assign release_in   = release_view & ~ctl.clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_RELEASED;
         change_time_ff <= '0;
         prev_raw_ff    <= 1'b0;
         press_ff       <= 1'b0;
         release_ff     <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         change_time_ff <= change_time_in;
         prev_raw_ff    <= prev_raw_in;
         press_ff       <= press_in;
         release_ff     <= release_in;
      end
   end

   assign stat.pressed      = (phase_in == PH_PRESSED);
   assign stat.press_flag   = press_view;
   assign stat.release_flag = release_view;
   assign stat.qualified    = ctl.sample & (step_press | step_release);

endmodule

@@ hdl/button_array_debouncer.sv @@
// top level of the button array debouncer
//
// Debounces up to eight buttons in parallel lanes. A request word either samples
// the raw button levels at a millisecond timestamp (command 0) or reads the sticky
// press and release flags and clears the lanes chosen by clear_select (command 1).
// Every request word yields exactly one response word carrying the debounced
// pressed mask and the flags; lanes at or above active_buttons read as zero and
// are not advanced by samples, though a read still clears their selected flags.
// A press or release qualifies once the raw level has held for debounce_ms,
// measured as the 32-bit wrapping difference from the lane's last phase change.
// Throughput is one word per cycle while the response side is not stalled: a request
// word lands in an input register, all lanes update in parallel with one subtract
// and compare each, and the response word is captured in an output register. A
// word accepted into the input register moves on to the output register, where it
// is offered as a valid response, once the output register is free or draining.
// A stalled response holds the next word in the input register, and req_ready
// drops once both registers are full. The user must write registers through the
// csr port only while no word is in flight; the block itself does not enforce this.
module button_array_debouncer (
   input  logic                                  clock,
   input  logic                                  reset,

   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_command,
   input  logic [btndb_pkg::BUTTONS_W-1:0]       req_raw_buttons,
   input  logic [btndb_pkg::TIME_W-1:0]          req_time_ms,
   input  logic [btndb_pkg::BUTTONS_W-1:0]       req_clear_select,

   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_any_changed,
   output logic [btndb_pkg::BUTTONS_W-1:0]       rsp_pressed_mask,
   output logic [btndb_pkg::BUTTONS_W-1:0]       rsp_press_flags,
   output logic [btndb_pkg::BUTTONS_W-1:0]       rsp_release_flags,

   // register write port
   input  logic                                  csr_write_enable,
   input  logic [btndb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [btndb_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   // configuration registers
   logic [btndb_pkg::DEBOUNCE_W-1:0] debounce_ms_ff;
   logic [btndb_pkg::ACTIVE_W-1:0]   active_buttons_ff;

   // input register
   logic                             in_valid_ff, in_valid_in;
   logic                             in_command_ff;
   logic [btndb_pkg::BUTTONS_W-1:0]  in_raw_ff;
   logic [btndb_pkg::TIME_W-1:0]     in_time_ff;
   logic [btndb_pkg::BUTTONS_W-1:0]  in_clear_ff;

   // output register
   logic                             out_valid_ff, out_valid_in;
   logic                             out_changed_ff;
   logic [btndb_pkg::BUTTONS_W-1:0]  out_pressed_ff, out_press_ff, out_release_ff;

   logic                             advance;
   logic                             req_take;

   btndb_pkg::lane_ctl_type  lane_ctl  [btndb_pkg::MAX_BUTTONS];
   btndb_pkg::lane_stat_type lane_stat [btndb_pkg::MAX_BUTTONS];

   logic [btndb_pkg::BUTTONS_W-1:0]  pressed_word, press_word, release_word, qual_word;
   logic [btndb_pkg::BUTTONS_W-1:0]  lane_active;

   // held word moves to the output register when that register is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff    <= btndb_pkg::DEBOUNCE_MS_RESET;
         active_buttons_ff <= btndb_pkg::ACTIVE_BUTTONS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            btndb_pkg::CSR_DEBOUNCE_MS: begin
               debounce_ms_ff <= csr_write_data[btndb_pkg::DEBOUNCE_W-1:0];
            end
            btndb_pkg::CSR_ACTIVE_BUTTONS: begin
               active_buttons_ff <= csr_write_data[btndb_pkg::ACTIVE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_raw_ff     <= req_raw_buttons;
         in_time_ff    <= req_time_ms;
         in_clear_ff   <= req_clear_select;
      end
   end

   // lane array; bits past the built lanes stay zero
   for (genvar i = 0; i < btndb_pkg::BUTTONS_W; i++) begin : g_lane
      if (i < btndb_pkg::MAX_BUTTONS) begin : g_used
         // an active count above the lane count leaves every lane active
         assign lane_active[i] = active_buttons_ff > btndb_pkg::ACTIVE_W'(i);

         assign lane_ctl[i].sample = advance & (in_command_ff == btndb_pkg::CMD_SAMPLE)
                                     & lane_active[i];
         assign lane_ctl[i].clear  = advance & (in_command_ff == btndb_pkg::CMD_READ)
                                     & in_clear_ff[i];
         assign lane_ctl[i].raw    = in_raw_ff[i];

         btndb_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .ctl         (lane_ctl[i]),
            .time_ms     (in_time_ff),
            .debounce_ms (debounce_ms_ff),
            .stat        (lane_stat[i])
         );

         assign pressed_word[i] = lane_stat[i].pressed      & lane_active[i];
         assign press_word[i]   = lane_stat[i].press_flag   & lane_active[i];
         assign release_word[i] = lane_stat[i].release_flag & lane_active[i];
         assign qual_word[i]    = lane_stat[i].qualified;
      end else begin : g_unused
         assign lane_active[i]  = 1'b0;
         assign pressed_word[i] = 1'b0;
         assign press_word[i]   = 1'b0;
         assign release_word[i] = 1'b0;
         assign qual_word[i]    = 1'b0;
      end
   end

   // response payload capture
   always_ff @(posedge clock) begin
      if (advance) begin
         out_changed_ff <= |qual_word;
         out_pressed_ff <= pressed_word;
         out_press_ff   <= press_word;
         out_release_ff <= release_word;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_any_changed   = out_changed_ff;
   assign rsp_pressed_mask  = out_pressed_ff;
   assign rsp_press_flags   = out_press_ff;
   assign rsp_release_flags = out_release_ff;

endmodule

@@ verif/tb.sv @@
// testbench for the button array debouncer: directed table, random button traffic, self-check
`timescale 1ns / 100ps

module tb;

   localparam int HALF_PERIOD = 10;
   localparam int RANDOM_PHASES = 13;
   localparam int WORDS_PER_PHASE = 100;

   // one response word as the block returns it
   typedef struct packed {
      logic                            any_changed;
      logic [btndb_pkg::BUTTONS_W-1:0] pressed_mask;
      logic [btndb_pkg::BUTTONS_W-1:0] press_flags;
      logic [btndb_pkg::BUTTONS_W-1:0] release_flags;
   } flags_word_type;

   // debounce phase of one lane
   typedef enum logic [1:0] {
      LANE_RELEASED,
      LANE_DEBOUNCE,
      LANE_PRESSED,
      LANE_RELEASING
   } lane_phase_type;

   // one row of the bring-up table: a register write or a request word,
   // with a hand-written response where it is obvious
   typedef struct packed {
      logic                              is_csr;
      logic [btndb_pkg::CSR_INDEX_W-1:0] csr_idx;
      logic [btndb_pkg::CSR_DATA_W-1:0]  csr_val;
      logic                              cmd;
      logic [btndb_pkg::BUTTONS_W-1:0]   raw;
      logic [btndb_pkg::TIME_W-1:0]      stamp;
      logic [btndb_pkg::BUTTONS_W-1:0]   sel;
      logic                              pinned;
      flags_word_type                    want;
   } bring_up_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_command = btndb_pkg::CMD_SAMPLE;
   logic [btndb_pkg::BUTTONS_W-1:0]   req_raw_buttons = '0;
   logic [btndb_pkg::TIME_W-1:0]      req_time_ms = '0;
   logic [btndb_pkg::BUTTONS_W-1:0]   req_clear_select = '0;

   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic                              rsp_any_changed;
   logic [btndb_pkg::BUTTONS_W-1:0]   rsp_pressed_mask;
   logic [btndb_pkg::BUTTONS_W-1:0]   rsp_press_flags;
   logic [btndb_pkg::BUTTONS_W-1:0]   rsp_release_flags;

   logic                              csr_write_enable = 1'b0;
   logic [btndb_pkg::CSR_INDEX_W-1:0] csr_index = btndb_pkg::CSR_DEBOUNCE_MS;
   logic [btndb_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   // hand-written expectation travelling with the request word
   logic           req_pinned = 1'b0;
   flags_word_type req_pin_word = '0;

   // no idling on either side while this is set
   logic calm = 1'b0;

   // lane model
   lane_phase_type                   lane_phase [btndb_pkg::MAX_BUTTONS];
   logic [btndb_pkg::TIME_W-1:0]     change_at  [btndb_pkg::MAX_BUTTONS];
   logic [btndb_pkg::BUTTONS_W-1:0]  prev_raw;
   logic [btndb_pkg::BUTTONS_W-1:0]  press_seen;
   logic [btndb_pkg::BUTTONS_W-1:0]  release_seen;
   logic [btndb_pkg::DEBOUNCE_W-1:0] hold_ms;
   logic [btndb_pkg::ACTIVE_W-1:0]   active_cfg;

   flags_word_type   pending_flags [$];
   bring_up_row_type bring_up_steps [$];
   int unsigned      mismatches = 0;

   button_array_debouncer uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_raw_buttons   (req_raw_buttons),
      .req_time_ms       (req_time_ms),
      .req_clear_select  (req_clear_select),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_any_changed   (rsp_any_changed),
      .rsp_pressed_mask  (rsp_pressed_mask),
      .rsp_press_flags   (rsp_press_flags),
      .rsp_release_flags (rsp_release_flags),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // response side backpressure, about a third of the cycles stalled
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 35);
   end

   // advance the lane model by one request word and return its response
   function automatic flags_word_type step_lanes(logic cmd,
                                                 logic [btndb_pkg::BUTTONS_W-1:0] raw,
                                                 logic [btndb_pkg::TIME_W-1:0] stamp,
                                                 logic [btndb_pkg::BUTTONS_W-1:0] sel);
      flags_word_type               w;
      int unsigned                  lanes;
      logic [btndb_pkg::TIME_W-1:0] held;
      logic                         done;
      w = '0;
      // counts above the lane total behave as all lanes
      lanes = (active_cfg > btndb_pkg::MAX_BUTTONS) ? btndb_pkg::MAX_BUTTONS
                                                    : 32'(active_cfg);
      if (cmd == btndb_pkg::CMD_SAMPLE) begin
         for (int i = 0; i < lanes; i++) begin
            held = stamp - change_at[i];   // wraps modulo 2^32
            done = held >= btndb_pkg::TIME_W'(hold_ms);
            case (lane_phase[i])
               LANE_RELEASED: begin
                  // only a fresh rising edge starts a press debounce
                  if (raw[i] && !prev_raw[i]) begin
                     lane_phase[i] = LANE_DEBOUNCE;
                     change_at[i] = stamp;
                  end
               end
               LANE_DEBOUNCE: begin
                  if (!raw[i]) begin
                     lane_phase[i] = LANE_RELEASED;
                     change_at[i] = stamp;
                  end else if (done) begin
                     lane_phase[i] = LANE_PRESSED;
                     change_at[i] = stamp;
                     press_seen[i] = 1'b1;
                     w.any_changed = 1'b1;
                  end
               end
               LANE_PRESSED: begin
                  if (!raw[i]) begin
                     lane_phase[i] = LANE_RELEASING;
                     change_at[i] = stamp;
                  end
               end
               default: begin
                  if (raw[i]) begin
                     lane_phase[i] = LANE_PRESSED;
                     change_at[i] = stamp;
                  end else if (done) begin
                     lane_phase[i] = LANE_RELEASED;
                     change_at[i] = stamp;
                     release_seen[i] = 1'b1;
                     w.any_changed = 1'b1;
                  end
               end
            endcase
            prev_raw[i] = raw[i];
         end
      end
      // inactive lanes read as zero
      for (int i = 0; i < lanes; i++) begin
         w.pressed_mask[i]  = (lane_phase[i] == LANE_PRESSED);
         w.press_flags[i]   = press_seen[i];
         w.release_flags[i] = release_seen[i];
      end
      // a read clears the selected flags on every lane, active or not
      if (cmd == btndb_pkg::CMD_READ) begin
         press_seen   = press_seen & ~sel;
         release_seen = release_seen & ~sel;
      end
      return w;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endtask

   // scoreboard: check response words, then predict the accepted request word
   always @(posedge clock) begin
      flags_word_type got;
      flags_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_any_changed, rsp_pressed_mask, rsp_press_flags, rsp_release_flags};
            if (pending_flags.size() == 0) begin
               report_mismatch("response word with nothing expected", 32'(got), 32'd0);
            end else begin
               want = pending_flags.pop_front();
               if (got.any_changed != want.any_changed)
                  report_mismatch("any_changed", 32'(got.any_changed),
                                  32'(want.any_changed));
               if (got.pressed_mask != want.pressed_mask)
                  report_mismatch("pressed_mask", 32'(got.pressed_mask),
                                  32'(want.pressed_mask));
               if (got.press_flags != want.press_flags)
                  report_mismatch("press_flags", 32'(got.press_flags),
                                  32'(want.press_flags));
               if (got.release_flags != want.release_flags)
                  report_mismatch("release_flags", 32'(got.release_flags),
                                  32'(want.release_flags));
            end
         end
         if (req_valid && req_ready) begin
            // the model always advances; a pinned word overrides its answer
            want = step_lanes(req_command, req_raw_buttons, req_time_ms, req_clear_select);
            if (req_pinned)
               want = req_pin_word;
            pending_flags.push_back(want);
         end
      end
   end

   // present one request word and hold it until accepted
   task automatic send_word(logic cmd, logic [btndb_pkg::BUTTONS_W-1:0] raw,
                            logic [btndb_pkg::TIME_W-1:0] stamp,
                            logic [btndb_pkg::BUTTONS_W-1:0] sel, logic pinned,
                            flags_word_type want);
      while (!calm && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_raw_buttons  <= raw;
      req_time_ms      <= stamp;
      req_clear_select <= sel;
      req_pinned       <= pinned;
      req_pin_word     <= want;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // let every word drain through the two-stage pipe
   task automatic drain_words();
      @(posedge clock);
      while (pending_flags.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write while the block is idle; the model follows at once
   task automatic write_reg(logic [btndb_pkg::CSR_INDEX_W-1:0] idx,
                            logic [btndb_pkg::CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      drain_words();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == btndb_pkg::CSR_DEBOUNCE_MS)
         hold_ms = data;
      else
         active_cfg = data[btndb_pkg::ACTIVE_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic bring_up_row_type sample_row(logic [btndb_pkg::BUTTONS_W-1:0] raw,
                                                   logic [btndb_pkg::TIME_W-1:0] stamp);
      bring_up_row_type r;
      r = '0;
      r.cmd = btndb_pkg::CMD_SAMPLE;
      r.raw = raw;
      r.stamp = stamp;
      return r;
   endfunction

   function automatic bring_up_row_type read_row(logic [btndb_pkg::BUTTONS_W-1:0] sel);
      bring_up_row_type r;
      r = '0;
      r.cmd = btndb_pkg::CMD_READ;
      r.sel = sel;
      return r;
   endfunction

   function automatic bring_up_row_type csr_row(logic [btndb_pkg::CSR_INDEX_W-1:0] idx,
                                                logic [btndb_pkg::CSR_DATA_W-1:0] val);
      bring_up_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val;
      return r;
   endfunction

   function automatic bring_up_row_type pin(bring_up_row_type r, flags_word_type want);
      r.pinned = 1'b1;
      r.want = want;
      return r;
   endfunction

   initial begin
      logic [btndb_pkg::DEBOUNCE_W-1:0] db;
      logic [btndb_pkg::ACTIVE_W-1:0]   act;
      logic [btndb_pkg::TIME_W-1:0]     now;
      logic [btndb_pkg::BUTTONS_W-1:0]  level;
      int unsigned                      span;
      int unsigned                      pick;

      // model starts in its reset state
      for (int i = 0; i < btndb_pkg::MAX_BUTTONS; i++) begin
         lane_phase[i] = LANE_RELEASED;
         change_at[i] = '0;
      end
      prev_raw = '0;
      press_seen = '0;
      release_seen = '0;
      hold_ms = btndb_pkg::DEBOUNCE_MS_RESET;
      active_cfg = btndb_pkg::ACTIVE_BUTTONS_RESET;

      // bring-up table, reset config first (50 ms, all eight lanes)
      bring_up_steps.push_back(pin(read_row(8'h00),
                                   flags_word_type'{1'b0, 8'h00, 8'h00, 8'h00}));
      bring_up_steps.push_back(pin(sample_row(8'hFF, 32'd0),
                                   flags_word_type'{1'b0, 8'h00, 8'h00, 8'h00}));
      // one ms short of the hold time
      bring_up_steps.push_back(pin(sample_row(8'hFF, 32'd49),
                                   flags_word_type'{1'b0, 8'h00, 8'h00, 8'h00}));
      // exactly the hold time qualifies every press
      bring_up_steps.push_back(pin(sample_row(8'hFF, 32'd50),
                                   flags_word_type'{1'b1, 8'hFF, 8'hFF, 8'h00}));
      // read returns flags before the clear
      bring_up_steps.push_back(pin(read_row(8'h0F),
                                   flags_word_type'{1'b0, 8'hFF, 8'hFF, 8'h00}));
      bring_up_steps.push_back(pin(read_row(8'h00),
                                   flags_word_type'{1'b0, 8'hFF, 8'hF0, 8'h00}));
      bring_up_steps.push_back(pin(sample_row(8'h00, 32'd60),
                                   flags_word_type'{1'b0, 8'h00, 8'hF0, 8'h00}));
      bring_up_steps.push_back(sample_row(8'h00, 32'd109));
      bring_up_steps.push_back(sample_row(8'h00, 32'd110));
      // debounce across the 32-bit wrap
      bring_up_steps.push_back(sample_row(8'hAA, 32'hFFFF_FFF0));
      bring_up_steps.push_back(sample_row(8'hAA, 32'h0000_0022));
      bring_up_steps.push_back(sample_row(8'h2A, 32'hFFFF_FFFF));
      bring_up_steps.push_back(read_row(8'hFF));
      // zero hold time qualifies on the next sample
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_DEBOUNCE_MS, 16'd0));
      bring_up_steps.push_back(sample_row(8'h55, 32'd5));
      bring_up_steps.push_back(sample_row(8'h55, 32'd5));
      bring_up_steps.push_back(sample_row(8'h0F, 32'd6));
      // three lanes only, read still clears inactive lanes
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_ACTIVE_BUTTONS, 16'hFFF3));
      bring_up_steps.push_back(sample_row(8'hFF, 32'd7));
      bring_up_steps.push_back(read_row(8'hF0));
      // active count above the lane total acts as eight
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_ACTIVE_BUTTONS, 16'd15));
      bring_up_steps.push_back(sample_row(8'h00, 32'd9));
      bring_up_steps.push_back(sample_row(8'hF0, 32'd9));
      // no lanes active: everything masked
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_ACTIVE_BUTTONS, 16'd0));
      bring_up_steps.push_back(pin(sample_row(8'hFF, 32'd10),
                                   flags_word_type'{1'b0, 8'h00, 8'h00, 8'h00}));
      bring_up_steps.push_back(pin(read_row(8'hFF),
                                   flags_word_type'{1'b0, 8'h00, 8'h00, 8'h00}));
      // longest hold time, with a drop during debounce on lane 7
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_ACTIVE_BUTTONS, 16'd8));
      bring_up_steps.push_back(csr_row(btndb_pkg::CSR_DEBOUNCE_MS, 16'hFFFF));
      bring_up_steps.push_back(sample_row(8'h00, 32'd1000));
      bring_up_steps.push_back(sample_row(8'hFF, 32'd1001));
      bring_up_steps.push_back(sample_row(8'hFF, 32'd1001 + 32'd65534));
      bring_up_steps.push_back(sample_row(8'h7F, 32'd1001 + 32'd65535));

      // hold synchronous reset, then release it
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (bring_up_steps[k]) begin
         if (bring_up_steps[k].is_csr)
            write_reg(bring_up_steps[k].csr_idx, bring_up_steps[k].csr_val);
         else
            send_word(bring_up_steps[k].cmd, bring_up_steps[k].raw, bring_up_steps[k].stamp,
                      bring_up_steps[k].sel, bring_up_steps[k].pinned,
                      bring_up_steps[k].want);
      end

      // random phases: mostly a running clock with bouncing buttons and
      // the occasional read, plus some noise words with arbitrary times
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 5))
            0: db = 16'd0;
            1: db = 16'($urandom_range(1, 5));
            2: db = 16'($urandom_range(6, 60));
            3: db = 16'hFFFF;
            4: db = 16'($urandom);
            default: db = 16'd50;
         endcase
         if (phase == 1)
            db = 16'hFFFF;
         act = ($urandom_range(0, 99) < 60) ? 4'd8 : 4'($urandom_range(0, 15));
         // both sides run flat out through one whole phase
         calm = (phase == 4);
         write_reg(btndb_pkg::CSR_DEBOUNCE_MS, db);
         write_reg(btndb_pkg::CSR_ACTIVE_BUTTONS, {12'($urandom), act});
         now = (phase % 3 == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535) : $urandom;
         level = 8'($urandom);
         span = int'(db) + int'(db) / 2 + 2;
         for (int k = 0; k < WORDS_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               send_word(btndb_pkg::CMD_READ, 8'($urandom), $urandom, 8'($urandom),
                         1'b0, '0);
            end else if (pick < 15) begin
               send_word(btndb_pkg::CMD_SAMPLE, 8'($urandom), $urandom, 8'($urandom),
                         1'b0, '0);
            end else begin
               // each button toggles with roughly one chance in eight
               now = now + $urandom_range(0, span);
               level = level ^ (8'($urandom) & 8'($urandom) & 8'($urandom));
               send_word(btndb_pkg::CMD_SAMPLE, level, now, 8'($urandom), 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      calm = 1'b0;
      drain_words();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
